[rtl/hrhs_pkg.sv]
// Shared types and constants for the HTTP response header scanner.
package hrhs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] declared_length;
    logic [15:0] body_offset;
    logic [15:0] body_bytes;
    logic [23:0] range_start;
    logic [23:0] range_end;
    logic [23:0] total_size;
  } out_word_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
    logic       is_lf;
    logic       is_cr;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] hex_val;
  } cls_word_t;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CHUNK  = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_LEN  = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_NO_BODY = 2'd3;

  localparam int unsigned LEN_PREFIX_SIZE = 15;
  localparam int unsigned RNG_PREFIX_SIZE = 14;

  function automatic logic [7:0] len_prefix(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "C";   4'd1: c = "o";   4'd2: c = "n";   4'd3: c = "t";
      4'd4: c = "e";   4'd5: c = "n";   4'd6: c = "t";   4'd7: c = "-";
      4'd8: c = "L";   4'd9: c = "e";   4'd10: c = "n";  4'd11: c = "g";
      4'd12: c = "t";  4'd13: c = "h";  4'd14: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rng_prefix(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "C";   4'd1: c = "o";   4'd2: c = "n";   4'd3: c = "t";
      4'd4: c = "e";   4'd5: c = "n";   4'd6: c = "t";   4'd7: c = "-";
      4'd8: c = "R";   4'd9: c = "a";   4'd10: c = "n";  4'd11: c = "g";
      4'd12: c = "e";  4'd13: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/hrhs_front.sv]
// Front part: classify each incoming byte.
module hrhs_front (
  input  hrhs_pkg::in_word_t  in_word,
  output hrhs_pkg::cls_word_t cls_word
);
  logic [7:0] up;

  always_comb begin
    up = in_word.data_byte;
    if (up >= 8'h61 && up <= 8'h7A) begin
      up = up - 8'h20;
    end
    cls_word.data_byte     = in_word.data_byte;
    cls_word.end_of_buffer = in_word.end_of_buffer;
    cls_word.is_lf         = (in_word.data_byte == 8'h0A);
    cls_word.is_cr         = (in_word.data_byte == 8'h0D);
    cls_word.is_digit      = (in_word.data_byte >= 8'h30) && (in_word.data_byte <= 8'h39);
    cls_word.digit         = 4'(in_word.data_byte - 8'h30);
    cls_word.hex_val       = (up < 8'h41) ? 4'(up - 8'h30) : 4'(up - 8'h37);
  end
endmodule

[rtl/hrhs_fifo.sv]
// Two-entry queue between the classifier and the scanner core.
module hrhs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  hrhs_pkg::cls_word_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output hrhs_pkg::cls_word_t rd_data,
  output logic                empty
);
  hrhs_pkg::cls_word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd_en)
    else $error("read from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
endmodule

[rtl/hrhs_core.sv]
// Back part: header line scanner, chunk size and result builder.
module hrhs_core #(
  parameter int unsigned MAX_LENGTH_DIGITS = 5,
  parameter int unsigned MAX_RANGE_DIGITS  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cw_valid,
  input  hrhs_pkg::cls_word_t cw,
  output logic                cw_take,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhs_pkg::out_word_t out_word
);
  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [1:0]  pm_r, pm_nxt;
  logic [1:0]  nidx_r, nidx_nxt;
  logic [2:0]  dcnt_r, dcnt_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [23:0] rv_r [3];
  logic [23:0] rv_nxt [3];
  logic [15:0] pos_r, bstart_r, bstart_nxt;
  logic        blank_r, blank_nxt;
  logic        ov_r;
  hrhs_pkg::out_word_t ow_r, ow_nxt;

  logic        len_line, rng_line, do_close, do_nl;
  logic [15:0] next_pos, offset, count;
  logic [2:0]  limit;
  logic [23:0] acc10;

  // Hold only an end-of-buffer word while the previous result waits.
  assign cw_take   = cw_valid && !(cw.end_of_buffer && ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_word  = ow_r;
  assign next_pos  = pos_r + 16'd1;
  assign acc10     = (acc_r << 3) + (acc_r << 1) + 24'(cw.digit);

  always_comb begin
    phase_nxt = phase_r; col_nxt = col_r; pm_nxt = pm_r; nidx_nxt = nidx_r;
    dcnt_nxt = dcnt_r; acc_nxt = acc_r; len_nxt = len_r; bstart_nxt = bstart_r;
    blank_nxt = blank_r;
    for (int i = 0; i < 3; i++) rv_nxt[i] = rv_r[i];
    len_line = pm_r[0] && (col_r >= 5'(hrhs_pkg::LEN_PREFIX_SIZE));
    rng_line = pm_r[1] && (col_r >= 5'(hrhs_pkg::RNG_PREFIX_SIZE));
    limit    = len_line ? 3'(MAX_LENGTH_DIGITS) : 3'(MAX_RANGE_DIGITS);
    do_close = 1'b0;
    do_nl    = 1'b0;
    if (phase_r == hrhs_pkg::PH_HEADER) begin
      if (cw.is_lf) begin
        do_nl = 1'b1;
        if (blank_r || col_r == 5'd0) begin
          if (len_r != 16'd0) begin
            phase_nxt  = hrhs_pkg::PH_BODY;
            bstart_nxt = next_pos;
          end else begin
            phase_nxt = hrhs_pkg::PH_CHUNK;
          end
        end else if (len_line || rng_line) begin
          do_close = 1'b1;
        end
      end else begin
        if (col_r == 5'd0 && cw.is_cr) blank_nxt = 1'b1;
        if (len_line || rng_line) begin
          if (cw.is_digit) begin
            if (dcnt_r < limit) begin
              acc_nxt  = acc10;
              dcnt_nxt = dcnt_r + 3'd1;
            end
          end else begin
            do_close = 1'b1;
          end
        end else begin
          if (col_r < 5'(hrhs_pkg::LEN_PREFIX_SIZE) &&
              cw.data_byte != hrhs_pkg::len_prefix(col_r[3:0])) pm_nxt[0] = 1'b0;
          if (col_r < 5'(hrhs_pkg::RNG_PREFIX_SIZE) &&
              cw.data_byte != hrhs_pkg::rng_prefix(col_r[3:0])) pm_nxt[1] = 1'b0;
          if (col_r == 5'(hrhs_pkg::RNG_PREFIX_SIZE - 1) && pm_nxt[1]) begin
            for (int i = 0; i < 3; i++) rv_nxt[i] = '0;
          end
        end
        if (col_r != 5'd31) col_nxt = col_r + 5'd1;
      end
      // Close an open digit run.
      if (do_close && dcnt_r != 3'd0) begin
        if (len_line) begin
          if (nidx_r == 2'd0 && acc_r[15:0] != 16'd0) len_nxt = acc_r[15:0];
        end else if (nidx_r != 2'd3) begin
          rv_nxt[nidx_r] = acc_r;
        end
        if (nidx_r != 2'd3) nidx_nxt = nidx_r + 2'd1;
        dcnt_nxt = 3'd0;
        acc_nxt  = '0;
      end
    end else if (phase_r == hrhs_pkg::PH_CHUNK) begin
      if (cw.is_lf) begin
        if (acc_r[15:0] != 16'd0) len_nxt = acc_r[15:0];
        do_nl      = 1'b1;
        phase_nxt  = hrhs_pkg::PH_BODY;
        bstart_nxt = next_pos;
      end else if (cw.is_cr) begin
        nidx_nxt = 2'd1;
      end else if (nidx_r == 2'd0) begin
        acc_nxt = {8'd0, acc_r[11:0], cw.hex_val};
      end
    end
    if (do_nl) begin
      col_nxt = '0; pm_nxt = 2'b11; nidx_nxt = '0; dcnt_nxt = '0;
      acc_nxt = '0; blank_nxt = 1'b0;
    end

    if (phase_nxt == hrhs_pkg::PH_BODY || phase_nxt == 2'd3) begin
      offset = bstart_nxt;
      count  = next_pos - bstart_nxt;
    end else begin
      offset = next_pos;
      count  = '0;
    end
    if (len_nxt == 16'd0)   ow_nxt.status = hrhs_pkg::ST_NO_LEN;
    else if (count == '0)   ow_nxt.status = hrhs_pkg::ST_NO_BODY;
    else if (len_nxt > count) ow_nxt.status = hrhs_pkg::ST_SHORT;
    else                    ow_nxt.status = hrhs_pkg::ST_OK;
    ow_nxt.declared_length = len_nxt;
    ow_nxt.body_offset     = offset;
    ow_nxt.body_bytes      = count;
    ow_nxt.range_start     = rv_nxt[0];
    ow_nxt.range_end       = rv_nxt[1];
    ow_nxt.total_size      = rv_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrhs_pkg::PH_HEADER; col_r <= '0; pm_r <= 2'b11; nidx_r <= '0;
      dcnt_r <= '0; acc_r <= '0; len_r <= '0; pos_r <= '0; bstart_r <= '0;
      blank_r <= 1'b0; ov_r <= 1'b0;
      for (int i = 0; i < 3; i++) rv_r[i] <= '0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cw_take) begin
        if (cw.end_of_buffer) begin
          // Hand off the result, then start over for the next buffer.
          ov_r <= 1'b1;
          ow_r <= ow_nxt;
          phase_r <= hrhs_pkg::PH_HEADER; col_r <= '0; pm_r <= 2'b11;
          nidx_r <= '0; dcnt_r <= '0; acc_r <= '0; len_r <= '0; pos_r <= '0;
          bstart_r <= '0; blank_r <= 1'b0;
          for (int i = 0; i < 3; i++) rv_r[i] <= '0;
        end else begin
          phase_r <= phase_nxt; col_r <= col_nxt; pm_r <= pm_nxt;
          nidx_r <= nidx_nxt; dcnt_r <= dcnt_nxt; acc_r <= acc_nxt;
          len_r <= len_nxt; pos_r <= next_pos; bstart_r <= bstart_nxt;
          blank_r <= blank_nxt;
          for (int i = 0; i < 3; i++) rv_r[i] <= rv_nxt[i];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) phase_r != 2'd3)
    else $error("unreachable phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    cw_take && cw.end_of_buffer |=> phase_r == hrhs_pkg::PH_HEADER && pos_r == '0)
    else $error("state not restarted after buffer end");
  assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= 3'(MAX_RANGE_DIGITS))
    else $error("digit count overrun");
endmodule

[rtl/http_response_header_scanner.sv]
// An end-of-buffer byte's result goes through the queue, then the result register.
// Throughput: one byte per cycle unless stalled; the core updates its state once per byte.
// While a result waits, bytes keep flowing until the next end-of-buffer word reaches the core.
// Reset (rst_n low, synchronous) empties the queue and returns to header scan.
// After each end-of-buffer byte the scanner restarts on its own for the next buffer.
module http_response_header_scanner #(
  parameter int unsigned MAX_LENGTH_DIGITS = 5,
  parameter int unsigned MAX_RANGE_DIGITS  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhs_pkg::out_word_t out_data
);
  hrhs_pkg::cls_word_t cls, q_data;
  logic full, empty, take;

  hrhs_front u_front (.in_word(in_data), .cls_word(cls));

  assign in_stall = full;

  hrhs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_valid && !full), .wr_data(cls), .full(full),
    .rd_en(take), .rd_data(q_data), .empty(empty)
  );

  hrhs_core #(
    .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS),
    .MAX_RANGE_DIGITS(MAX_RANGE_DIGITS)
  ) u_core (
    .clk(clk), .rst_n(rst_n),
    .cw_valid(!empty), .cw(q_data), .cw_take(take),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_data)
  );
endmodule

[tb/sv/http_response_header_scanner_chk.sv]
// Checker for the HTTP response header scanner: predicts each result and compares it.
`timescale 1ns / 1ps
module http_response_header_scanner_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  hrhs_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  hrhs_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending
);
  localparam int unsigned LEN_DIGITS = 5;
  localparam int unsigned RNG_DIGITS = 7;

  logic [1:0]  phase;
  logic [4:0]  column;
  logic [1:0]  prefix_ok;
  logic [1:0]  run_index;
  logic [2:0]  digits;
  logic [23:0] accum;
  logic [15:0] length_reg;
  logic [23:0] range_val [3];
  logic [15:0] position;
  logic [15:0] body_pos;
  logic        blank;

  hrhs_pkg::out_word_t result_q [$];

  assign pending = result_q.size();

  function automatic logic [7:0] len_char(int unsigned i);
    string s;
    s = "Content-Length:";
    return s[i];
  endfunction

  function automatic logic [7:0] rng_char(int unsigned i);
    string s;
    s = "Content-Range:";
    return s[i];
  endfunction

  task automatic start_line();
    column = 0;
    prefix_ok = 2'b11;
    run_index = 0;
    digits = 0;
    accum = 0;
    blank = 1'b0;
  endtask

  task automatic clear_scan();
    phase = hrhs_pkg::PH_HEADER;
    length_reg = 0;
    range_val[0] = 0;
    range_val[1] = 0;
    range_val[2] = 0;
    position = 0;
    body_pos = 0;
    start_line();
  endtask

  task automatic end_run(bit is_len);
    if (digits == 0) return;
    if (is_len) begin
      if (run_index == 0 && accum[15:0] != 0) length_reg = accum[15:0];
    end else if (run_index < 3) begin
      range_val[run_index] = accum;
    end
    if (run_index < 3) run_index++;
    digits = 0;
    accum = 0;
  endtask

  task automatic scan_header(logic [7:0] b, logic [15:0] next_pos);
    bit len_line;
    bit rng_line;
    int unsigned lim;
    len_line = prefix_ok[0] && column >= hrhs_pkg::LEN_PREFIX_SIZE;
    rng_line = prefix_ok[1] && column >= hrhs_pkg::RNG_PREFIX_SIZE;
    if (b == 8'h0a) begin
      if (blank || column == 0) begin
        start_line();
        if (length_reg != 0) begin
          phase = hrhs_pkg::PH_BODY;
          body_pos = next_pos;
        end else begin
          phase = hrhs_pkg::PH_CHUNK;
        end
        return;
      end
      if (len_line || rng_line) end_run(len_line);
      start_line();
      return;
    end
    if (column == 0 && b == 8'h0d) blank = 1'b1;
    if (len_line || rng_line) begin
      lim = len_line ? LEN_DIGITS : RNG_DIGITS;
      if (b >= "0" && b <= "9") begin
        if (digits < lim) begin
          accum = 24'(accum * 24'd10 + 24'(b - 8'h30));
          digits++;
        end
      end else begin
        end_run(len_line);
      end
    end else begin
      if (column < hrhs_pkg::LEN_PREFIX_SIZE && b != len_char(column)) prefix_ok[0] = 1'b0;
      if (column < hrhs_pkg::RNG_PREFIX_SIZE && b != rng_char(column)) prefix_ok[1] = 1'b0;
      if (column == hrhs_pkg::RNG_PREFIX_SIZE - 1 && prefix_ok[1]) begin
        range_val[0] = 0;
        range_val[1] = 0;
        range_val[2] = 0;
      end
    end
    if (column < 31) column++;
  endtask

  task automatic scan_chunk(logic [7:0] b, logic [15:0] next_pos);
    logic [7:0] c;
    logic [7:0] v;
    if (b == 8'h0a) begin
      if (accum != 0) length_reg = accum[15:0];
      start_line();
      phase = hrhs_pkg::PH_BODY;
      body_pos = next_pos;
    end else if (b == 8'h0d) begin
      run_index = 1;
    end else if (run_index == 0) begin
      c = b;
      if (c >= "a" && c <= "z") c -= 8'h20;
      v = (c < 8'h41) ? c - 8'h30 : c - 8'h37;
      accum = {8'h00, accum[11:0], v[3:0]};
    end
  endtask

  task automatic take_byte(hrhs_pkg::in_word_t w);
    logic [15:0] next_pos;
    hrhs_pkg::out_word_t r;
    next_pos = position + 16'd1;
    if (phase == hrhs_pkg::PH_HEADER) scan_header(w.data_byte, next_pos);
    else if (phase == hrhs_pkg::PH_CHUNK) scan_chunk(w.data_byte, next_pos);
    if (!w.end_of_buffer) begin
      position = next_pos;
      return;
    end
    if (phase >= hrhs_pkg::PH_BODY) begin
      r.body_offset = body_pos;
      r.body_bytes = next_pos - body_pos;
    end else begin
      r.body_offset = next_pos;
      r.body_bytes = 0;
    end
    r.declared_length = length_reg;
    if (length_reg == 0) r.status = hrhs_pkg::ST_NO_LEN;
    else if (r.body_bytes == 0) r.status = hrhs_pkg::ST_NO_BODY;
    else if (length_reg > r.body_bytes) r.status = hrhs_pkg::ST_SHORT;
    else r.status = hrhs_pkg::ST_OK;
    r.range_start = range_val[0];
    r.range_end = range_val[1];
    r.total_size = range_val[2];
    result_q.push_back(r);
    clear_scan();
  endtask

  always @(posedge clk) begin
    hrhs_pkg::out_word_t want;
    if (!rst_n) begin
      fail_count = 0;
      clear_scan();
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) take_byte(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          want = result_q.pop_front();
          if (want.status !== out_data.status ||
              want.declared_length !== out_data.declared_length ||
              want.body_offset !== out_data.body_offset ||
              want.body_bytes !== out_data.body_bytes ||
              want.range_start !== out_data.range_start ||
              want.range_end !== out_data.range_end ||
              want.total_size !== out_data.total_size) begin
            fail_count++;
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          end
        end
      end
    end
  end
endmodule

[tb/sv/http_response_header_scanner_tb.sv]
// Top of the scanner testbench: builds response buffers, drives and stalls, gives the verdict.
`timescale 1ns / 1ps
module http_response_header_scanner_tb;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  hrhs_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  hrhs_pkg::out_word_t out_data;
  int fail_count;
  int pending;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_recv;
  int sent_bytes;

  http_response_header_scanner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  http_response_header_scanner_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver stall, random or held for a long stretch.
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Valid stays high after the word is taken; the next call or the caller drops it.
  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_buffer: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_body(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string hex_digits(int n);
    string s;
    string h;
    h = "0123456789abcdefABCDEFxg";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(h[$urandom_range(23)])};
    return s;
  endfunction

  // One well-formed response with random content, sometimes broken.
  task automatic send_response();
    int nlines;
    int pick;
    nlines = $urandom_range(3);
    send_str("HTTP/1.1 200 OK\r\n");
    for (int i = 0; i < nlines; i++) begin
      pick = $urandom_range(5);
      case (pick)
        0: send_str({"Content-Length: ", rand_digits($urandom_range(1, 7)), "\r\n"});
        1: send_str({"Content-Range: bytes ", rand_digits($urandom_range(0, 9)), "-",
                     rand_digits($urandom_range(0, 9)), "/",
                     rand_digits($urandom_range(0, 9)), "\r\n"});
        2: send_str({"Content-Length:", rand_digits($urandom_range(1, 3)), " ",
                     rand_digits(2), "\n"});
        3: send_str({"Content-Rangx: 5-6/7\r\n"});
        4: send_str({"X-", hex_digits($urandom_range(0, 35)), "\r\n"});
        default: send_str({"Content-Range:", rand_digits(3), "\r\n"});
      endcase
    end
    if ($urandom_range(9) == 0) begin
      send_byte(8'($urandom), 1'b1);
      return;
    end
    send_str($urandom_range(1) ? "\r\n" : "\n");
    if ($urandom_range(3) == 0) send_str({hex_digits($urandom_range(0, 5)), "\r;x\r\n"});
    if ($urandom_range(7) == 0) send_str({hex_digits(3), "\n"});
    send_body($urandom_range(1, 12));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_recv = 1'b0;
    sent_bytes = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed buffers.
    send_str("HTTP/1.1 200 OK\r\nContent-Length: 4\r\n\r\n");
    send_body(4);
    send_str("Content-Length: 99999\r\nContent-Range: bytes 9999999-12345678/0\r\n\r\n");
    send_body(3);
    send_str("Content-Length: 0\r\n\r\n1aF\r;ext\r\nAB");
    send_byte(8'hff, 1'b1);
    send_str("\n");
    send_byte(8'h00, 1'b1);
    send_str("Content-Length: 5\r\n\r\n");
    send_byte("\n", 1'b1);
    send_str("Content-Range: 7\r\nContent-Length: 12");
    send_byte("3", 1'b1);
    send_byte(8'h80, 1'b1);

    send_idle_pct = 28;
    recv_idle_pct = 53;
    while (sent_bytes < 700) send_response();

    // Long receiver hold while bytes keep coming.
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(negedge clk);
        hold_recv = 1'b0;
      end
      begin
        repeat (8) send_response();
        in_valid <= 1'b0;
      end
    join
    // Drain before going on.
    while (pending != 0) @(negedge clk);

    send_idle_pct = 53;
    recv_idle_pct = 28;
    while (sent_bytes < 1300) send_response();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_bytes < 1800) send_response();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
